// ===== design/lohc_pkg.sv =====
// Package with the shared types and constants of the open handle cache.
package lohc_pkg;

   // Fixed widths of the channel fields.
   localparam int unsigned ID_PORT_W = 16;
   localparam int unsigned COUNT_PORT_W = 5;
   localparam int unsigned LIMIT_W = 5;

   // Reset value of the open limit register.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // Defaults and bounds of the top level parameters.
   localparam int unsigned CAPACITY_DEFAULT = 16;
   localparam int unsigned SLOT_ID_BITS_DEFAULT = 16;
   localparam int unsigned CAPACITY_MAX = 64;
   localparam int unsigned IDX_MAX_W = 6;

   // Command codes.
   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } lohc_state_type;

   // Kinds of update applied to the rank table.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_CLOSE,
      OP_TOUCH,
      OP_OPEN
   } lohc_op_type;

   // One update of the rank table.
   typedef struct packed {
      lohc_op_type kind;
      logic evict;
      logic [IDX_MAX_W-1:0] hit_idx;
      logic [IDX_MAX_W-1:0] hit_age;
      logic [IDX_MAX_W-1:0] victim_idx;
      logic [IDX_MAX_W-1:0] fill_idx;
   } lohc_upd_type;

endpackage

// ===== design/lohc_if.sv =====
// Channel interfaces for command beats and result beats.
interface lohc_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic [lohc_pkg::ID_PORT_W-1:0] slot_id;

   modport source (output valid, output cmd, output slot_id, input ready);
   modport sink (input valid, input cmd, input slot_id, output ready);
endinterface

interface lohc_rsp_if;
   logic valid;
   logic ready;
   logic was_open;
   logic evicted;
   logic [lohc_pkg::ID_PORT_W-1:0] evicted_slot;
   logic [lohc_pkg::COUNT_PORT_W-1:0] open_count;

   modport source (output valid, output was_open, output evicted, output evicted_slot,
                   output open_count, input ready);
   modport sink (input valid, input was_open, input evicted, input evicted_slot,
                 input open_count, output ready);
endinterface

// ===== design/lru_open_handle_cache_unit.sv =====
// Top level of the least-recently-used open handle cache.
//
// Command beats arrive on req_bus: cmd 0 touches or opens slot_id, cmd 1 closes it.
// Every command gives one result beat on rsp_bus: the hit flag, the eviction flag
// with the evicted slot id, and the number of open entries afterward.
// The open limit is written through csr_wr_en and csr_wr_data; the user must write
// it only while idle, which the block itself does not enforce. A limit of 0 acts
// as 1 and one above CAPACITY acts as CAPACITY. Slot ids live in a synchronous
// memory with one read port and one write port that is scanned one entry a cycle;
// recency ranks and valid marks live in flip-flops updated in parallel. A command
// passes through the accept step, a scan of every entry through the registered
// memory read port, and one update step.
// The result sits in an output register, so the next command is accepted while
// it waits; if the result is still not taken when the next update is due, the
// update waits until the receiver takes it.
// Reset clears all valid marks and the open count and sets the limit to 16 at once.
module lru_open_handle_cache_unit #(
   parameter int unsigned CAPACITY = lohc_pkg::CAPACITY_DEFAULT,
   parameter int unsigned SLOT_ID_BITS = lohc_pkg::SLOT_ID_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   lohc_req_if.sink                      req_bus,
   lohc_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [lohc_pkg::LIMIT_W-1:0]  csr_wr_data
);

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = COUNT_W + lohc_pkg::LIMIT_W + 1;
   localparam int unsigned IDX_EXT_W = IDX_W + lohc_pkg::IDX_MAX_W;
   localparam int unsigned ID_EXT_W = SLOT_ID_BITS + lohc_pkg::ID_PORT_W;
   localparam int unsigned CNT_EXT_W = COUNT_W + lohc_pkg::COUNT_PORT_W;

   lohc_pkg::lohc_state_type state_ff, state_in;

   logic [lohc_pkg::LIMIT_W-1:0] limit_ff;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic                         cmd_ff, cmd_in;
   logic [SLOT_ID_BITS-1:0]      id_ff, id_in;
   logic [COUNT_W-1:0]           scan_cnt_ff, scan_cnt_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]             cmp_idx_ff, cmp_idx_in;
   logic                         hit_ff, hit_in;
   logic [IDX_W-1:0]             hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]             hit_age_ff, hit_age_in;
   logic [IDX_W-1:0]             vic_idx_ff, vic_idx_in;
   logic [SLOT_ID_BITS-1:0]      vic_id_ff, vic_id_in;
   logic                         free_found_ff, free_found_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_was_open_ff, rsp_was_open_in;
   logic                                  rsp_evicted_ff, rsp_evicted_in;
   logic [lohc_pkg::ID_PORT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [lohc_pkg::COUNT_PORT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                    req_take;
   logic [IDX_W-1:0]        rd_addr;
   logic [SLOT_ID_BITS-1:0] rd_data;
   logic                    mem_wr_en;
   logic [IDX_W-1:0]        fill_idx;
   logic                    ent_valid;
   logic [IDX_W-1:0]        ent_age;
   logic                    full;
   logic                    evict;
   logic [CMP_W-1:0]        cmp_count;
   logic [CMP_W-1:0]        cmp_limit;
   lohc_pkg::lohc_upd_type  upd;

   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == lohc_pkg::ST_IDLE);

   lohc_slot_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (SLOT_ID_BITS),
      .AW    (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (fill_idx),
      .wr_data (id_ff)
   );

   lohc_rank_table #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_rank_table (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .rd_idx   (cmp_idx_ff),
      .rd_valid (ent_valid),
      .rd_age   (ent_age)
   );

   // Effective limit, clamped to 1..CAPACITY, against the open count.
   always_comb begin
      cmp_count = CMP_W'(count_ff);
      cmp_limit = CMP_W'(limit_ff);
      if (cmp_limit == '0) begin
         cmp_limit = CMP_W'(1);
      end else if (cmp_limit > CMP_W'(CAPACITY)) begin
         cmp_limit = CMP_W'(CAPACITY);
      end
      full = (cmp_count >= cmp_limit);
   end

   assign evict = (cmd_ff == lohc_pkg::CMD_ACCESS) && !hit_ff && full;

   // An eviction frees the victim, which wins when it sits below the first hole.
   assign fill_idx = (evict && (!free_found_ff || vic_idx_ff < free_idx_ff)) ?
                     vic_idx_ff : free_idx_ff;

   // Sequencer: accept, scan the memory, then commit the update and the result.
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      id_in = id_ff;
      scan_cnt_in = scan_cnt_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = scan_cnt_ff[IDX_W-1:0];
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_age_in = hit_age_ff;
      vic_idx_in = vic_idx_ff;
      vic_id_in = vic_id_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      count_in = count_ff;
      rd_addr = scan_cnt_ff[IDX_W-1:0];
      mem_wr_en = 1'b0;
      upd = '0;
      upd.kind = lohc_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_was_open_in = rsp_was_open_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;

      case (state_ff)
         lohc_pkg::ST_IDLE: begin
            if (req_take) begin
               cmd_in = req_bus.cmd;
               // Only the low SLOT_ID_BITS bits of the id take part.
               id_in = SLOT_ID_BITS'(ID_EXT_W'(req_bus.slot_id));
               scan_cnt_in = '0;
               hit_in = 1'b0;
               free_found_in = 1'b0;
               state_in = lohc_pkg::ST_SCAN;
            end
         end
         lohc_pkg::ST_SCAN: begin
            // Issue one read a cycle while entries remain.
            if (scan_cnt_ff < COUNT_W'(CAPACITY)) begin
               cmp_vld_in = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            // Examine the entry whose read data has just arrived.
            if (cmp_vld_ff) begin
               if (ent_valid && rd_data == id_ff) begin
                  hit_in = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  hit_age_in = ent_age;
               end
               if (ent_valid && COUNT_W'(ent_age) == count_ff - 1'b1) begin
                  vic_idx_in = cmp_idx_ff;
                  vic_id_in = rd_data;
               end
               if (!ent_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == IDX_W'(CAPACITY - 1)) begin
                  state_in = lohc_pkg::ST_UPDATE;
               end
            end
         end
         lohc_pkg::ST_UPDATE: begin
            // Commit once the output register is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               upd.hit_idx = lohc_pkg::IDX_MAX_W'(IDX_EXT_W'(hit_idx_ff));
               upd.hit_age = lohc_pkg::IDX_MAX_W'(IDX_EXT_W'(hit_age_ff));
               upd.victim_idx = lohc_pkg::IDX_MAX_W'(IDX_EXT_W'(vic_idx_ff));
               upd.fill_idx = lohc_pkg::IDX_MAX_W'(IDX_EXT_W'(fill_idx));
               upd.evict = evict;
               if (cmd_ff == lohc_pkg::CMD_CLOSE) begin
                  if (hit_ff) begin
                     upd.kind = lohc_pkg::OP_CLOSE;
                     count_in = count_ff - 1'b1;
                  end
               end else if (hit_ff) begin
                  upd.kind = lohc_pkg::OP_TOUCH;
               end else begin
                  upd.kind = lohc_pkg::OP_OPEN;
                  mem_wr_en = 1'b1;
                  if (!evict) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_was_open_in = hit_ff;
               rsp_evicted_in = evict;
               rsp_slot_in = evict ? lohc_pkg::ID_PORT_W'(ID_EXT_W'(vic_id_ff)) : '0;
               rsp_count_in = lohc_pkg::COUNT_PORT_W'(CNT_EXT_W'(count_in));
               state_in = lohc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lohc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lohc_pkg::ST_IDLE;
         count_ff <= '0;
         limit_ff <= lohc_pkg::LIMIT_RESET;
         cmp_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Payload and scan bookkeeping registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      id_ff <= id_in;
      scan_cnt_ff <= scan_cnt_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_age_ff <= hit_age_in;
      vic_idx_ff <= vic_idx_in;
      vic_id_ff <= vic_id_in;
      free_found_ff <= free_found_in;
      free_idx_ff <= free_idx_in;
      rsp_was_open_ff <= rsp_was_open_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.was_open = rsp_was_open_ff;
   assign rsp_bus.evicted = rsp_evicted_ff;
   assign rsp_bus.evicted_slot = rsp_slot_ff;
   assign rsp_bus.open_count = rsp_count_ff;

   // A hit never evicts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.was_open && rsp_bus.evicted))
      else $error("result beat reports both a hit and an eviction");

   // The open count never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("open count exceeds capacity");

   // An accepted command starts the scan.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == lohc_pkg::ST_SCAN)
      else $error("accepted command did not start a scan");

   // A miss that opens an entry always has a free place to fill.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lohc_pkg::ST_UPDATE && mem_wr_en) |-> (free_found_ff || evict))
      else $error("open without a free entry");

endmodule

// ===== design/lohc_slot_mem.sv =====
// Synchronous memory holding the slot id of each table entry.
module lohc_slot_mem #(
   parameter int unsigned DEPTH = lohc_pkg::CAPACITY_DEFAULT,
   parameter int unsigned WIDTH = lohc_pkg::SLOT_ID_BITS_DEFAULT,
   parameter int unsigned AW = 4
) (
   input  logic             clock,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] slot_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   // One read port with registered data.
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lohc_rank_table.sv =====
// Valid marks and recency ranks of the entries, with parallel rank updates.
module lohc_rank_table #(
   parameter int unsigned CAPACITY = lohc_pkg::CAPACITY_DEFAULT,
   parameter int unsigned IDX_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lohc_pkg::lohc_upd_type upd,
   input  logic [IDX_W-1:0]     rd_idx,
   output logic                 rd_valid,
   output logic [IDX_W-1:0]     rd_age
);

   logic             valid_ff [CAPACITY];
   logic             valid_in [CAPACITY];
   logic [IDX_W-1:0] age_ff [CAPACITY];
   logic [IDX_W-1:0] age_in [CAPACITY];

   // Every entry computes its own next valid mark and rank.
   always_comb begin
      logic [lohc_pkg::IDX_MAX_W-1:0] pos;
      logic [IDX_W-1:0] ref_age;
      ref_age = upd.hit_age[IDX_W-1:0];
      for (int i = 0; i < CAPACITY; i++) begin
         pos = lohc_pkg::IDX_MAX_W'(i);
         valid_in[i] = valid_ff[i];
         age_in[i] = age_ff[i];
         case (upd.kind)
            lohc_pkg::OP_CLOSE: begin
               if (pos == upd.hit_idx) begin
                  valid_in[i] = 1'b0;
                  age_in[i] = '0;
               end else if (valid_ff[i] && age_ff[i] > ref_age) begin
                  age_in[i] = age_ff[i] - 1'b1;
               end
            end
            lohc_pkg::OP_TOUCH: begin
               if (pos == upd.hit_idx) begin
                  age_in[i] = '0;
               end else if (valid_ff[i] && age_ff[i] < ref_age) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end
            lohc_pkg::OP_OPEN: begin
               if (upd.evict && pos == upd.victim_idx) begin
                  valid_in[i] = 1'b0;
                  age_in[i] = '0;
               end else if (valid_ff[i]) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
               if (pos == upd.fill_idx) begin
                  valid_in[i] = 1'b1;
                  age_in[i] = '0;
               end
            end
            default: begin
               valid_in[i] = valid_ff[i];
            end
         endcase
      end
   end

   // Marks and ranks clear at reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
            age_ff[i] <= '0;
         end else begin
            valid_ff[i] <= valid_in[i];
            age_ff[i] <= age_in[i];
         end
      end
   end

   // The scan reads one entry a cycle.
   assign rd_valid = valid_ff[rd_idx];
   assign rd_age = age_ff[rd_idx];

endmodule

// ===== dv/tb_lru_open_handle_cache_unit.sv =====
// LRU open handle cache testbench: directed and random commands checked against a recency model.
`timescale 1ns / 100ps

module tb_lru_open_handle_cache_unit;

   localparam int unsigned CAP = 16;

   typedef struct packed {
      logic       cmd;
      logic [15:0] slot_id;
   } cmd_beat_type;

   typedef struct packed {
      logic        was_open;
      logic        evicted;
      logic [15:0] evicted_slot;
      logic [4:0]  open_count;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [lohc_pkg::LIMIT_W-1:0] csr_wr_data = '0;

   lohc_req_if req_bus ();
   lohc_rsp_if rsp_bus ();

   lru_open_handle_cache_unit dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model of the handle table.
   logic [15:0] mdl_slot [CAP];
   logic        mdl_valid [CAP];
   int unsigned mdl_age [CAP];
   int unsigned mdl_count;
   logic [4:0]  mdl_limit;

   cmd_beat_type pending_cmds[$];
   rsp_beat_type expected_rsps[$];
   int errors = 0;
   int hold_off = 0;
   int sent = 0;
   int send_gap = 0;
   int take_gap = 0;

   // Remove one entry and close the gap in the ranks above it.
   function automatic void drop_handle(int k);
      int unsigned a;
      a = mdl_age[k];
      mdl_valid[k] = 1'b0;
      mdl_age[k] = 0;
      for (int i = 0; i < CAP; i++)
         if (mdl_valid[i] && mdl_age[i] > a) mdl_age[i]--;
      if (mdl_count > 0) mdl_count--;
   endfunction

   // Apply one command to the table and return the result it should give.
   function automatic rsp_beat_type cache_lookup(cmd_beat_type c);
      rsp_beat_type r;
      int k, victim, freei;
      int unsigned lim, a;
      r = '0;
      k = -1;
      for (int i = 0; i < CAP; i++)
         if (k < 0 && mdl_valid[i] && mdl_slot[i] == c.slot_id) k = i;
      if (c.cmd == lohc_pkg::CMD_CLOSE) begin
         if (k >= 0) begin
            r.was_open = 1'b1;
            drop_handle(k);
         end
      end else if (k >= 0) begin
         r.was_open = 1'b1;
         a = mdl_age[k];
         for (int i = 0; i < CAP; i++)
            if (mdl_valid[i] && mdl_age[i] < a) mdl_age[i]++;
         mdl_age[k] = 0;
      end else begin
         lim = 32'(mdl_limit);
         if (lim < 1) lim = 1;
         if (lim > CAP) lim = CAP;
         victim = -1;
         freei = -1;
         if (mdl_count >= lim) begin
            for (int i = 0; i < CAP; i++)
               if (mdl_valid[i] && (victim < 0 || mdl_age[i] > mdl_age[victim])) victim = i;
            if (victim >= 0) begin
               r.evicted = 1'b1;
               r.evicted_slot = mdl_slot[victim];
               drop_handle(victim);
            end
         end
         for (int i = 0; i < CAP; i++)
            if (freei < 0 && !mdl_valid[i]) freei = i;
         if (freei >= 0) begin
            for (int i = 0; i < CAP; i++)
               if (mdl_valid[i]) mdl_age[i]++;
            mdl_slot[freei] = c.slot_id;
            mdl_valid[freei] = 1'b1;
            mdl_age[freei] = 0;
            mdl_count++;
         end
      end
      r.open_count = mdl_count[4:0];
      return r;
   endfunction

   // Driver: offers queued command beats with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_bus.ready) begin
         // Hold the beat until it is taken.
      end else begin
         if (req_bus.valid) begin
            expected_rsps.push_back(cache_lookup(pending_cmds.pop_front()));
            sent++;
            send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.cmd <= pending_cmds[0].cmd;
            req_bus.slot_id <= pending_cmds[0].slot_id;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: takes result beats with random stalls and checks them.
   always @(posedge clock) begin
      rsp_beat_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat with no command waiting");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_bus.was_open !== e.was_open) begin
                  $error("was_open expected %0d actual %0d", e.was_open, rsp_bus.was_open);
                  errors++;
               end
               if (rsp_bus.evicted !== e.evicted) begin
                  $error("evicted expected %0d actual %0d", e.evicted, rsp_bus.evicted);
                  errors++;
               end
               if (rsp_bus.evicted_slot !== e.evicted_slot) begin
                  $error("evicted_slot expected %0h actual %0h", e.evicted_slot,
                         rsp_bus.evicted_slot);
                  errors++;
               end
               if (rsp_bus.open_count !== e.open_count) begin
                  $error("open_count expected %0d actual %0d", e.open_count,
                         rsp_bus.open_count);
                  errors++;
               end
            end
            take_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_bus.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Queue one command beat.
   task automatic queue_cmd(logic c, logic [15:0] id);
      cmd_beat_type b;
      b.cmd = c;
      b.slot_id = id;
      pending_cmds.push_back(b);
   endtask

   // Wait until every queued beat is sent and answered, then let the block settle.
   task automatic drain_all();
      while (pending_cmds.size() > 0 || req_bus.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (CAP + 8) @(posedge clock);
   endtask

   // Write the open limit while the block is idle.
   task automatic set_limit(logic [4:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mdl_limit = v;
      @(posedge clock);
   endtask

   // Random phase: ids drawn from a small pool so hits and evictions are common.
   task automatic random_phase(int n, int pool);
      logic [15:0] base;
      base = 16'($urandom);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            queue_cmd(1'($urandom_range(0, 1)), 16'($urandom));
         else
            queue_cmd($urandom_range(0, 3) == 0, base ^ 16'($urandom_range(0, pool - 1)));
      end
   endtask

   initial begin
      logic [4:0] limits [6];
      limits = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd9};
      for (int i = 0; i < CAP; i++) begin
         mdl_valid[i] = 1'b0;
         mdl_age[i] = 0;
         mdl_slot[i] = '0;
      end
      mdl_count = 0;
      mdl_limit = lohc_pkg::LIMIT_RESET;
      req_bus.valid = 1'b0;
      req_bus.cmd = 1'b0;
      req_bus.slot_id = '0;
      rsp_bus.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme ids, fill to the reset limit, hit, close miss, evict.
      queue_cmd(lohc_pkg::CMD_CLOSE, 16'h0000);
      queue_cmd(lohc_pkg::CMD_ACCESS, 16'h0000);
      queue_cmd(lohc_pkg::CMD_ACCESS, 16'hFFFF);
      queue_cmd(lohc_pkg::CMD_ACCESS, 16'h0000);
      queue_cmd(lohc_pkg::CMD_CLOSE, 16'hFFFF);
      queue_cmd(lohc_pkg::CMD_CLOSE, 16'hFFFF);
      for (int i = 1; i <= 17; i++) queue_cmd(lohc_pkg::CMD_ACCESS, 16'h5A00 + 16'(i));
      queue_cmd(lohc_pkg::CMD_ACCESS, 16'h5A05);
      drain_all();

      // Limit lowered below the open count: misses keep evicting one each.
      set_limit(5'd2);
      queue_cmd(lohc_pkg::CMD_ACCESS, 16'h1234);
      queue_cmd(lohc_pkg::CMD_ACCESS, 16'hABCD);
      queue_cmd(lohc_pkg::CMD_CLOSE, 16'h1234);
      // Long receiver stall so the block fills and backs up its input.
      hold_off = 200;
      random_phase(20, 8);
      drain_all();

      for (int p = 0; p < 6; p++) begin
         set_limit(limits[p]);
         random_phase(95, (p % 2) ? 24 : 6);
         drain_all();
      end

      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Timeout guard.
   initial begin
      #6000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/lohc_pkg.sv
design/lohc_if.sv
design/lohc_slot_mem.sv
design/lohc_rank_table.sv
design/lru_open_handle_cache_unit.sv
dv/tb_lru_open_handle_cache_unit.sv
